// ===== sv/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by the parser, the top level and the checker.

package wsfd_pkg;

    // Default width of the payload length counter
    localparam int LENGTH_BITS_DEF = 64;

    // Reset value of the largest accepted payload length
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'(512 * 1024);

    // Ping payload bytes echoed at most
    localparam logic [6:0] PONG_CAP = 7'd125;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Extended length and mask key byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // Result kinds
    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_EMPTY_DATA = 3'd1;
    localparam logic [2:0] KIND_PONG       = 3'd2;
    localparam logic [2:0] KIND_EMPTY_PONG = 3'd3;
    localparam logic [2:0] KIND_CLOSE      = 3'd4;
    localparam logic [2:0] KIND_OVERSIZE   = 3'd5;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_MASK = 5'b01000,
        PH_PAY  = 5'b10000
    } t_phase;

    // What happens to payload bytes of the current frame
    typedef enum logic [1:0] {
        MODE_DROP = 2'd0,
        MODE_DATA = 2'd1,
        MODE_PONG = 2'd2
    } t_mode;

    // One result item plus its valid flag
    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [3:0] msg_opcode;
        logic       frame_last;
    } t_result;

endpackage

// ===== sv/websocket_frame_deframer_top.sv =====
// A byte is taken into the input register, and its result then into the result register.
// Throughput: one byte per cycle; the input register and the result
// register both advance whenever the result register is empty or taken.
// Reset (synchronous, active low) clears the frame state, empties both
// registers and sets max_payload to 524288.
// Top level of the WebSocket frame deframer; depends on wsfd_pkg and wsfd_parser.

module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_msg_opcode,
    output logic        o_frame_last,
    // max_payload write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic [31:0]        r_max_payload;
    wsfd_pkg::t_result  r_out;
    wsfd_pkg::t_result  step_res;
    logic               adv;

    // Pipeline moves when the result register is free or being taken
    assign adv     = !r_out.valid || !i_stall;
    assign o_stall = r_in_valid && !adv;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= wsfd_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_payload <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_in_valid || adv) && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    wsfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_in_valid && adv),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_res         (step_res)
    );

    // Result register; the parser only flags a result on a stepped byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_valid      = r_out.valid;
    assign o_kind       = r_out.kind;
    assign o_data_byte  = r_out.data_byte;
    assign o_msg_opcode = r_out.msg_opcode;
    assign o_frame_last = r_out.frame_last;

endmodule

// ===== sv/wsfd_parser.sv =====
// Frame parser: header capture, length tracking, unmasking and result select.
// Depends on wsfd_pkg. Holds all frame state; one byte is processed per step.

module wsfd_parser #(
    parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_max_payload,
    output wsfd_pkg::t_result o_res
);

    localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    wsfd_pkg::t_phase         r_phase, n_phase;
    wsfd_pkg::t_mode          r_mode, n_mode;
    logic [3:0]               r_hdr_cnt, n_hdr_cnt;
    logic                     r_final, n_final;
    logic [3:0]               r_frame_op, n_frame_op;
    logic                     r_mask_on, n_mask_on;
    logic [31:0]              r_mask_key, n_mask_key;
    logic [LENGTH_BITS-1:0]   r_left, n_left;
    logic [1:0]               r_mask_idx, n_mask_idx;
    logic                     r_frag_open, n_frag_open;
    logic [3:0]               r_frag_op, n_frag_op;
    logic [6:0]               r_pong_cnt, n_pong_cnt;
    logic                     r_closed, n_closed;

    logic [LENGTH_BITS-1:0]   ext_len;
    logic [LENGTH_BITS-1:0]   hdr_len;
    logic                     do_end;
    logic [3:0]               data_op;
    logic [1:0]               key_sel;
    logic [7:0]               key_byte;
    logic                     pay_last;
    wsfd_pkg::t_mode          mode_v;
    wsfd_pkg::t_result        res;

    // Extended length shift-in, saturating at all ones
    assign ext_len = (|r_left[LENGTH_BITS-1 -: 8]) ? '1 : {r_left[LENGTH_BITS-9:0], i_byte};

    // Opcode that payload is delivered under
    assign data_op = (r_frame_op == wsfd_pkg::OP_CONT) ? r_frag_op : r_frame_op;

    // Key byte for this payload byte, most significant first
    assign key_sel  = ~r_mask_idx;
    assign key_byte = r_mask_key[{key_sel, 3'b000} +: 8];
    assign pay_last = (r_left == LENGTH_BITS'(1));

    // Next state and result for one byte
    always_comb begin
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_hdr_cnt   = r_hdr_cnt;
        n_final     = r_final;
        n_frame_op  = r_frame_op;
        n_mask_on   = r_mask_on;
        n_mask_key  = r_mask_key;
        n_left      = r_left;
        n_mask_idx  = r_mask_idx;
        n_frag_open = r_frag_open;
        n_frag_op   = r_frag_op;
        n_pong_cnt  = r_pong_cnt;
        n_closed    = r_closed;
        res         = '0;
        do_end      = 1'b0;
        hdr_len     = r_left;
        mode_v      = wsfd_pkg::MODE_DROP;

        if (i_step && !r_closed) begin
            unique case (r_phase)
                wsfd_pkg::PH_HDR0: begin
                    n_final    = i_byte[7];
                    n_frame_op = i_byte[3:0];
                    n_phase    = wsfd_pkg::PH_HDR1;
                end
                wsfd_pkg::PH_HDR1: begin
                    n_mask_on  = i_byte[7];
                    n_mask_key = '0;
                    if (i_byte[6:0] == wsfd_pkg::LEN_EXT16 ||
                        i_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
                        n_left    = '0;
                        n_hdr_cnt = (i_byte[6:0] == wsfd_pkg::LEN_EXT16) ?
                                    wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                        n_phase   = wsfd_pkg::PH_EXT;
                    end else begin
                        n_left  = LENGTH_BITS'(i_byte[6:0]);
                        hdr_len = LENGTH_BITS'(i_byte[6:0]);
                        if (i_byte[7]) begin
                            n_hdr_cnt = wsfd_pkg::MASK_BYTES;
                            n_phase   = wsfd_pkg::PH_MASK;
                        end else begin
                            do_end = 1'b1;
                        end
                    end
                end
                wsfd_pkg::PH_EXT: begin
                    n_left    = ext_len;
                    hdr_len   = ext_len;
                    n_hdr_cnt = r_hdr_cnt - 4'd1;
                    if (n_hdr_cnt == 4'd0) begin
                        if (r_mask_on) begin
                            n_hdr_cnt = wsfd_pkg::MASK_BYTES;
                            n_phase   = wsfd_pkg::PH_MASK;
                        end else begin
                            do_end = 1'b1;
                        end
                    end
                end
                wsfd_pkg::PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_hdr_cnt  = r_hdr_cnt - 4'd1;
                    if (n_hdr_cnt == 4'd0) begin
                        do_end = 1'b1;
                    end
                end
                wsfd_pkg::PH_PAY: begin
                    n_mask_idx = r_mask_idx + 2'd1;
                    n_left     = r_left - LENGTH_BITS'(1);
                    if (pay_last) begin
                        n_phase = wsfd_pkg::PH_HDR0;
                    end
                    if (r_mode == wsfd_pkg::MODE_DATA) begin
                        res = '{1'b1, wsfd_pkg::KIND_DATA, i_byte ^ key_byte, data_op, pay_last};
                    end else if (r_mode == wsfd_pkg::MODE_PONG &&
                                 r_pong_cnt < wsfd_pkg::PONG_CAP) begin
                        n_pong_cnt = r_pong_cnt + 7'd1;
                        res = '{1'b1, wsfd_pkg::KIND_PONG, i_byte ^ key_byte, 4'd0,
                                pay_last || (n_pong_cnt == wsfd_pkg::PONG_CAP)};
                    end
                end
                default: begin
                    n_phase = wsfd_pkg::PH_HDR0;
                end
            endcase

            // End of header: classify the frame
            if (do_end) begin
                n_mask_idx = '0;
                n_pong_cnt = '0;
                n_phase    = wsfd_pkg::PH_PAY;
                if (CW'(hdr_len) > CW'(i_max_payload)) begin
                    res = '{1'b1, wsfd_pkg::KIND_OVERSIZE, 8'd0, 4'd0, 1'b1};
                end else begin
                    unique case (r_frame_op)
                        wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY: begin
                            if (r_final && !r_frag_open) begin
                                mode_v = wsfd_pkg::MODE_DATA;
                            end
                            if (!r_final) begin
                                n_frag_open = 1'b1;
                                n_frag_op   = r_frame_op;
                            end
                        end
                        wsfd_pkg::OP_CONT: begin
                            if (r_final) begin
                                if (r_frag_open) begin
                                    mode_v = wsfd_pkg::MODE_DATA;
                                end
                                n_frag_open = 1'b0;
                            end
                        end
                        wsfd_pkg::OP_CLOSE: begin
                            n_closed = 1'b1;
                        end
                        wsfd_pkg::OP_PING: begin
                            mode_v = wsfd_pkg::MODE_PONG;
                        end
                        default: begin
                            mode_v = wsfd_pkg::MODE_DROP;
                        end
                    endcase

                    if (r_frame_op == wsfd_pkg::OP_CLOSE) begin
                        n_phase = wsfd_pkg::PH_HDR0;
                        res = '{1'b1, wsfd_pkg::KIND_CLOSE, 8'd0, 4'd0, 1'b1};
                    end else if (hdr_len == '0) begin
                        n_phase = wsfd_pkg::PH_HDR0;
                        if (mode_v == wsfd_pkg::MODE_DATA) begin
                            res = '{1'b1, wsfd_pkg::KIND_EMPTY_DATA, 8'd0, data_op, 1'b1};
                        end else if (mode_v == wsfd_pkg::MODE_PONG) begin
                            res = '{1'b1, wsfd_pkg::KIND_EMPTY_PONG, 8'd0, 4'd0, 1'b1};
                        end
                    end
                end
                n_mode = mode_v;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsfd_pkg::PH_HDR0;
            r_mode      <= wsfd_pkg::MODE_DROP;
            r_hdr_cnt   <= '0;
            r_final     <= 1'b0;
            r_frame_op  <= '0;
            r_mask_on   <= 1'b0;
            r_mask_key  <= '0;
            r_left      <= '0;
            r_mask_idx  <= '0;
            r_frag_open <= 1'b0;
            r_frag_op   <= '0;
            r_pong_cnt  <= '0;
            r_closed    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_mode      <= n_mode;
            r_hdr_cnt   <= n_hdr_cnt;
            r_final     <= n_final;
            r_frame_op  <= n_frame_op;
            r_mask_on   <= n_mask_on;
            r_mask_key  <= n_mask_key;
            r_left      <= n_left;
            r_mask_idx  <= n_mask_idx;
            r_frag_open <= n_frag_open;
            r_frag_op   <= n_frag_op;
            r_pong_cnt  <= n_pong_cnt;
            r_closed    <= n_closed;
        end
    end

    assign o_res = res;

endmodule

// ===== sv/wsfd_checker.sv =====
// Port-level checker for the WebSocket frame deframer, bound to the top level.
// Depends on wsfd_pkg.

module wsfd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [2:0]  o_kind,
    input  logic [7:0]  o_data_byte,
    input  logic [3:0]  o_msg_opcode,
    input  logic        o_frame_last,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_msg_opcode) && $stable(o_frame_last))
        else $error("stalled result changed");

    // Only defined result kinds appear
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind <= wsfd_pkg::KIND_OVERSIZE)
        else $error("undefined result kind");

    // Byte-less results end their frame and carry no byte
    a_byteless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != wsfd_pkg::KIND_DATA && o_kind != wsfd_pkg::KIND_PONG
            |-> o_frame_last && o_data_byte == 8'd0)
        else $error("byte-less result malformed");

    // Only data results carry a message opcode
    a_opcode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != wsfd_pkg::KIND_DATA && o_kind != wsfd_pkg::KIND_EMPTY_DATA
            |-> o_msg_opcode == 4'd0)
        else $error("opcode on non-data result");

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (.*);
